### sv/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// When the condition holds, the consequence must hold at the following clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("%m: check failed");

`endif

### sv/wcrf_pkg.sv
`timescale 1ns / 1ps

package wcrf_pkg;

	localparam int COL_W = 10;
	localparam int ROW_W = 9;
	localparam int CNT_W = 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_ROI_ROW_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_ROW_LAST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_WIDTH = 2'd2;

	localparam logic [ROW_W-1:0] ROI_ROW_FIRST_RST = 9'd120;
	localparam logic [ROW_W-1:0] ROI_ROW_LAST_RST  = 9'd450;
	localparam logic [COL_W-1:0] MIN_RUN_WIDTH_RST = 10'd24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [ROW_W-1:0] first;
		logic [ROW_W-1:0] last;
	} wcrf_roi_t;

	// One closed run and/or the frame end, passed from front to back.
	typedef struct packed {
		logic             has_run;
		logic             fe;
		logic [COL_W-1:0] left;
		logic [COL_W-1:0] right;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] count;
	} wcrf_event_t;

endpackage

### sv/wcrf_if.sv
`timescale 1ns / 1ps

interface wcrf_pixel_if import wcrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pixel_on;
	logic [ROW_W-1:0] pixel_row;
	logic [COL_W-1:0] pixel_col;
	logic             frame_end;

	modport source (output valid, pixel_on, pixel_row, pixel_col, frame_end, input ready);
	modport sink (input valid, pixel_on, pixel_row, pixel_col, frame_end, output ready);
endinterface

interface wcrf_result_if import wcrf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic [COL_W-1:0]        run_left;
	logic [COL_W-1:0]        run_right;
	logic [ROW_W-1:0]        run_row;
	logic [COL_W-1:0]        run_width;
	logic [COL_W-1:0]        center_col;
	logic signed [COL_W-1:0] center_offset;
	logic [CNT_W-1:0]        set_pixel_count;

	modport source (output valid, status, run_left, run_right, run_row, run_width,
		center_col, center_offset, set_pixel_count, input ready);
	modport sink (input valid, status, run_left, run_right, run_row, run_width,
		center_col, center_offset, set_pixel_count, output ready);
endinterface

### sv/wcrf_front.sv
`timescale 1ns / 1ps

module wcrf_front import wcrf_pkg::*; #(
	parameter int COLS = 640,
	parameter int ROWS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	wcrf_pixel_if.sink  pixel,
	input  wcrf_roi_t   roi,
	input  logic        q_full,
	output logic        push,
	output wcrf_event_t push_event
);

	localparam logic [COL_W-1:0] ColsLim = COL_W'(COLS);
	localparam logic [COL_W-1:0] LastCol = COL_W'(COLS - 1);
	localparam logic [ROW_W:0]   RowsLim = (ROW_W + 1)'(ROWS);

	logic             run_open_q;
	logic [COL_W-1:0] run_begin_q;
	logic [CNT_W-1:0] set_count_q;

	logic             accept;
	logic             in_win;
	logic             open_nx;
	logic [COL_W-1:0] begin_nx;
	logic [CNT_W-1:0] count_nx;
	logic             close;

	assign pixel.ready = !q_full;
	assign accept = pixel.valid && pixel.ready;

	assign in_win = (pixel.pixel_row >= roi.first) && (pixel.pixel_row <= roi.last) &&
		({1'b0, pixel.pixel_row} < RowsLim) && (pixel.pixel_col < ColsLim);

	always_comb begin
		open_nx  = run_open_q;
		begin_nx = run_begin_q;
		count_nx = set_count_q;
		close    = 1'b0;
		if (in_win) begin
			// A column at or before the open run's start means the row restarted.
			open_nx = run_open_q && (pixel.pixel_col > run_begin_q);
			if (pixel.pixel_on) begin
				if (set_count_q != {CNT_W{1'b1}}) begin
					count_nx = set_count_q + CNT_W'(1);
				end
				if (!open_nx) begin
					open_nx  = 1'b1;
					begin_nx = pixel.pixel_col;
				end
			end
			close = open_nx && (!pixel.pixel_on || pixel.pixel_col == LastCol ||
				pixel.frame_end);
			if (close) begin
				open_nx = 1'b0;
			end
		end
	end

	always_comb begin
		push_event.has_run = close;
		push_event.fe      = pixel.frame_end;
		push_event.left    = begin_nx;
		push_event.right   = pixel.pixel_on ? pixel.pixel_col : pixel.pixel_col - COL_W'(1);
		push_event.row     = pixel.pixel_row;
		push_event.count   = count_nx;
	end

	assign push = accept && (close || pixel.frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_begin_q <= '0;
			set_count_q <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				run_open_q  <= 1'b0;
				run_begin_q <= '0;
				set_count_q <= '0;
			end else begin
				run_open_q  <= open_nx;
				run_begin_q <= begin_nx;
				set_count_q <= count_nx;
			end
		end
	end

endmodule

### sv/wcrf_queue.sv
`timescale 1ns / 1ps

module wcrf_queue import wcrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  wcrf_event_t push_event,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output wcrf_event_t head
);

	wcrf_event_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full       = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

### sv/wcrf_back.sv
`timescale 1ns / 1ps

module wcrf_back import wcrf_pkg::*; #(
	parameter int COLS = 640
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  wcrf_event_t      head,
	output logic             pop,
	input  logic [COL_W-1:0] min_run_width,
	wcrf_result_if.source    result
);

	localparam logic [COL_W:0]   ColsDbl  = (COL_W + 1)'(COLS);
	localparam logic [COL_W-1:0] HalfCols = COL_W'(COLS / 2);

	logic [COL_W-1:0] best_left_q;
	logic [COL_W-1:0] best_right_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_width_q;
	logic [COL_W-1:0] best_off_q;

	logic             out_valid_q;
	logic             status_q;
	logic [COL_W-1:0] left_q;
	logic [COL_W-1:0] right_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] width_q;
	logic [COL_W-1:0] center_q;
	logic [COL_W-1:0] offset_q;
	logic [CNT_W-1:0] count_q;

	logic [COL_W-1:0] cand_width;
	logic [COL_W:0]   cand_dbl;
	logic [COL_W:0]   cand_off;
	logic             take;
	logic [COL_W-1:0] nb_left;
	logic [COL_W-1:0] nb_right;
	logic [ROW_W-1:0] nb_row;
	logic [COL_W-1:0] nb_width;
	logic [COL_W-1:0] nb_off;
	logic [COL_W:0]   nb_dbl;
	logic [COL_W-1:0] nb_center;
	logic [COL_W-1:0] nb_offset;

	assign pop = head_valid && (!head.fe || !out_valid_q || result.ready);

	always_comb begin
		cand_width = head.right - head.left + COL_W'(1);
		cand_dbl   = {1'b0, head.left} + {1'b0, head.right};
		cand_off   = (cand_dbl >= ColsDbl) ? cand_dbl - ColsDbl : ColsDbl - cand_dbl;
		// Wider wins; on a tie the doubled center must sit strictly closer to the middle.
		take = head.has_run && ((cand_width > best_width_q) ||
			(cand_width == best_width_q && cand_off < {1'b0, best_off_q}));
		nb_left  = take ? head.left : best_left_q;
		nb_right = take ? head.right : best_right_q;
		nb_row   = take ? head.row : best_row_q;
		nb_width = take ? cand_width : best_width_q;
		nb_off   = take ? cand_off[COL_W-1:0] : best_off_q;
		nb_dbl    = {1'b0, nb_left} + {1'b0, nb_right};
		nb_center = nb_dbl[COL_W:1];
		nb_offset = (nb_width != '0) ? nb_center - HalfCols : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_left_q  <= '0;
			best_right_q <= '0;
			best_row_q   <= '0;
			best_width_q <= '0;
			best_off_q   <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				if (head.fe) begin
					best_left_q  <= '0;
					best_right_q <= '0;
					best_row_q   <= '0;
					best_width_q <= '0;
					best_off_q   <= '1;
				end else begin
					best_left_q  <= nb_left;
					best_right_q <= nb_right;
					best_row_q   <= nb_row;
					best_width_q <= nb_width;
					best_off_q   <= nb_off;
				end
			end
			if (pop && head.fe) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.fe) begin
			status_q <= (nb_width < min_run_width);
			left_q   <= nb_left;
			right_q  <= nb_right;
			row_q    <= nb_row;
			width_q  <= nb_width;
			center_q <= nb_center;
			offset_q <= nb_offset;
			count_q  <= head.count;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = status_q;
	assign result.run_left        = left_q;
	assign result.run_right       = right_q;
	assign result.run_row         = row_q;
	assign result.run_width       = width_q;
	assign result.center_col      = center_q;
	assign result.center_offset   = offset_q;
	assign result.set_pixel_count = count_q;

endmodule

### sv/widest_centered_run_finder.sv
// Throughput: one pixel per clock; the front takes a pixel every cycle the event queue has room.
// A frame-end pixel is written into the event queue as it is accepted; its result is loaded into the
// output register once the back pops it from the queue, which a stalled result can hold off.
// A stalled result holds off the back only on the next frame-end, so the queue absorbs short stalls.
// Reset (arst_n low, asynchronous) clears the run, best-run and count state and the queue,
// and restores the row window and minimum width registers to their defaults.
`timescale 1ns / 1ps

module widest_centered_run_finder import wcrf_pkg::*; #(
	parameter int COLS = 640,
	parameter int ROWS = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wcrf_pixel_if.sink            pixel,
	wcrf_result_if.source         result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ROW_W-1:0] roi_row_first_q;
	logic [ROW_W-1:0] roi_row_last_q;
	logic [COL_W-1:0] min_run_width_q;

	wcrf_roi_t   roi;
	logic        q_full;
	logic        push;
	wcrf_event_t push_event;
	logic        pop;
	logic        head_valid;
	wcrf_event_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_row_first_q <= ROI_ROW_FIRST_RST;
			roi_row_last_q  <= ROI_ROW_LAST_RST;
			min_run_width_q <= MIN_RUN_WIDTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ROI_ROW_FIRST: roi_row_first_q <= cfg_data[ROW_W-1:0];
				CFG_ROI_ROW_LAST:  roi_row_last_q  <= cfg_data[ROW_W-1:0];
				CFG_MIN_RUN_WIDTH: min_run_width_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	assign roi.first = roi_row_first_q;
	assign roi.last  = roi_row_last_q;

	wcrf_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.roi        (roi),
		.q_full     (q_full),
		.push       (push),
		.push_event (push_event)
	);

	wcrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_event (push_event),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	wcrf_back #(.COLS(COLS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.min_run_width (min_run_width_q),
		.result        (result)
	);

endmodule

### sv/wcrf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wcrf_checker import wcrf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [COL_W-1:0]        run_left,
	input logic [COL_W-1:0]        run_right,
	input logic [COL_W-1:0]        run_width,
	input logic [COL_W-1:0]        center_col,
	input logic signed [COL_W-1:0] center_offset
);

	logic [COL_W:0] span_sum;

	assign span_sum = {1'b0, run_left} + {1'b0, run_right};

	// A stalled result stays up with the same run.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(run_left) && $stable(run_right) && $stable(run_width))

	// A reported run's width agrees with its end columns.
	`ASSERT_ALWAYS(a_width_span, clk, arst_n, !(res_valid && run_width != '0) || (run_right >= run_left && run_width == run_right - run_left + COL_W'(1)))

	// With no run, every run and center field reads zero.
	`ASSERT_ALWAYS(a_empty_zero, clk, arst_n, !(res_valid && run_width == '0) || (run_left == '0 && run_right == '0 && center_col == '0 && center_offset == '0))

	// The center column is the floor of the mean of the end columns.
	`ASSERT_ALWAYS(a_center, clk, arst_n, !res_valid || center_col == span_sum[COL_W:1])

endmodule

bind widest_centered_run_finder wcrf_checker u_wcrf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.run_left      (result.run_left),
	.run_right     (result.run_right),
	.run_width     (result.run_width),
	.center_col    (result.center_col),
	.center_offset (result.center_offset)
);
